FILE: rtl/pnu_pkg.sv
// Shared types, codes and helpers for the palette nearest upscaler.
package pnu_pkg;

  localparam int MODE_W  = 2;
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int COORD_W = 12;

  localparam logic [MODE_W-1:0] MODE_PAL_WR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PIX_WR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RD     = 2'd2;

  typedef enum logic [1:0] {
    OP_IDLE   = 2'd0,
    OP_PAL_WR = 2'd1,
    OP_PIX_WR = 2'd2,
    OP_RD     = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [15:0] data;
  } item_t;

  typedef struct packed {
    logic        we;
    logic        re;
    logic [7:0]  addr;
    logic [15:0] wdata;
  } pal_req_t;

  function automatic logic [15:0] to_565(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

FILE: rtl/pnu_div_pipe.sv
// Constant divider by reciprocal multiplication, one register stage, with clamp.
module pnu_div_pipe #(
  parameter int DW      = 18,
  parameter int QW      = 8,
  parameter int DIVISOR = 320,
  parameter int LIMIT   = 239
) (
  input  logic          clk,
  input  logic [DW-1:0] dividend,
  input  logic          clamp,
  output logic [QW-1:0] quotient
);

  localparam int SH = DW + 12;
  localparam int MW = SH + 1;
  localparam int PW = DW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [PW-1:0] prod;
  logic          clp;

  always_ff @(posedge clk) begin
    prod <= PW'(dividend) * PW'(RECIP);
    clp  <= clamp;
  end

  assign quotient = clp ? QW'(LIMIT) : QW'(prod >> SH);

endmodule

FILE: rtl/pnu_frame_mem.sv
// Single-port indexed source frame store with registered read.
module pnu_frame_mem #(
  parameter int DEPTH = 38400,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/pnu_palette_mem.sv
// Single-port 256-entry RGB565 palette store with registered read.
module pnu_palette_mem (
  input  logic              clk,
  input  pnu_pkg::pal_req_t req,
  output logic [15:0]       rdata
);

  logic [15:0] mem [0:255];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

FILE: rtl/palette_nearest_upscaler_top.sv
// Palette nearest upscaler: ordered write/read pipeline over frame and palette stores.
// Throughput: one transaction per cycle; busy stays low, start is always taken.
// Read path: a read's color565 shows with done after its registered steps, in order:
//   scale, address, frame read, palette read.
// Writes land at the frame or palette stage in transaction order; stores are not cleared.
// Reset (rst, synchronous) empties the pipeline; store contents are kept.
module palette_nearest_upscaler_top #(
  parameter int SRC_WIDTH  = 240,
  parameter int SRC_HEIGHT = 160,
  parameter int DST_WIDTH  = 320,
  parameter int DST_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  pal_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [15:0] pixel_addr,
  input  logic [7:0]  pixel_value,
  input  logic [8:0]  dest_x,
  input  logic [7:0]  dest_y,
  output logic        done,
  output logic [15:0] color565
);

  localparam int QWX     = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int QWY     = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int QW      = (QWX > QWY) ? QWX : QWY;
  localparam int DWX     = pnu_pkg::X_W + $clog2(SRC_WIDTH + 1);
  localparam int DWY     = pnu_pkg::Y_W + $clog2(SRC_HEIGHT + 1);
  localparam int FDEPTH  = SRC_WIDTH * SRC_HEIGHT;
  localparam int FAW     = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int DIV_LAT = 1;
  localparam int LAT     = DIV_LAT + 4;

  logic            accept;
  pnu_pkg::item_t  item_in;
  pnu_pkg::item_t  itm [0:DIV_LAT];
  logic [DWX-1:0]  px;
  logic [DWY-1:0]  py;
  logic            clamp_x;
  logic            clamp_y;
  logic [QW-1:0]   sx;
  logic [QW-1:0]   sy;

  pnu_pkg::item_t  item_m;
  pnu_pkg::item_t  item_f;
  logic [FAW-1:0]  f_addr;
  logic            f_we;
  logic            f_re;
  logic [7:0]      f_wdata;
  logic [7:0]      f_rdata;
  logic            pix_in_range;

  pnu_pkg::pal_req_t pal_req;
  logic [15:0]       pal_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    item_in.addr = 16'(pal_index);
    item_in.data = pnu_pkg::to_565(red, green, blue);
    case (mode)
      pnu_pkg::MODE_PAL_WR: item_in.op = pnu_pkg::OP_PAL_WR;
      pnu_pkg::MODE_PIX_WR: begin
        item_in.op   = pnu_pkg::OP_PIX_WR;
        item_in.addr = pixel_addr;
        item_in.data = 16'(pixel_value);
      end
      pnu_pkg::MODE_RD:     item_in.op = pnu_pkg::OP_RD;
      default:              item_in.op = pnu_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    px      <= DWX'(dest_x) * DWX'(SRC_WIDTH);
    py      <= DWY'(dest_y) * DWY'(SRC_HEIGHT);
    clamp_x <= pnu_pkg::COORD_W'(dest_x) >= pnu_pkg::COORD_W'(DST_WIDTH);
    clamp_y <= pnu_pkg::COORD_W'(dest_y) >= pnu_pkg::COORD_W'(DST_HEIGHT);
    if (rst) begin
      for (int k = 0; k <= DIV_LAT; k++) begin
        itm[k].op <= pnu_pkg::OP_IDLE;
      end
    end else begin
      itm[0].op   <= accept ? item_in.op : pnu_pkg::OP_IDLE;
      itm[0].addr <= item_in.addr;
      itm[0].data <= item_in.data;
      for (int k = 1; k <= DIV_LAT; k++) begin
        itm[k] <= itm[k-1];
      end
    end
  end

  pnu_div_pipe #(
    .DW      (DWX),
    .QW      (QW),
    .DIVISOR (DST_WIDTH),
    .LIMIT   (SRC_WIDTH - 1)
  ) u_div_x (
    .clk      (clk),
    .dividend (px),
    .clamp    (clamp_x),
    .quotient (sx)
  );

  pnu_div_pipe #(
    .DW      (DWY),
    .QW      (QW),
    .DIVISOR (DST_HEIGHT),
    .LIMIT   (SRC_HEIGHT - 1)
  ) u_div_y (
    .clk      (clk),
    .dividend (py),
    .clamp    (clamp_y),
    .quotient (sy)
  );

  assign pix_in_range = 32'(itm[DIV_LAT].addr) < 32'(FDEPTH);

  always_ff @(posedge clk) begin
    f_wdata <= itm[DIV_LAT].data[7:0];
    if (itm[DIV_LAT].op == pnu_pkg::OP_RD) begin
      f_addr <= FAW'(FAW'(sy) * FAW'(SRC_WIDTH) + FAW'(sx));
    end else begin
      f_addr <= FAW'(itm[DIV_LAT].addr);
    end
    if (rst) begin
      item_m.op <= pnu_pkg::OP_IDLE;
      f_we      <= 1'b0;
      f_re      <= 1'b0;
    end else begin
      item_m <= itm[DIV_LAT];
      f_we   <= (itm[DIV_LAT].op == pnu_pkg::OP_PIX_WR) && pix_in_range;
      f_re   <= itm[DIV_LAT].op == pnu_pkg::OP_RD;
    end
  end

  pnu_frame_mem #(
    .DEPTH (FDEPTH),
    .AW    (FAW)
  ) u_frame (
    .clk   (clk),
    .we    (f_we),
    .re    (f_re),
    .addr  (f_addr),
    .wdata (f_wdata),
    .rdata (f_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_f.op <= pnu_pkg::OP_IDLE;
    end else begin
      item_f <= item_m;
    end
  end

  always_comb begin
    pal_req.we    = item_f.op == pnu_pkg::OP_PAL_WR;
    pal_req.re    = item_f.op == pnu_pkg::OP_RD;
    pal_req.addr  = pal_req.re ? f_rdata : item_f.addr[7:0];
    pal_req.wdata = item_f.data;
  end

  pnu_palette_mem u_palette (
    .clk   (clk),
    .req   (pal_req),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pal_req.re;
    end
  end

  assign color565 = pal_rdata;

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == pnu_pkg::MODE_RD) |-> ##LAT done)
    else $error("read transaction produced no result");

  a_write_gives_none: assert property (@(posedge clk) disable iff (rst)
    (accept && mode != pnu_pkg::MODE_RD) |-> ##LAT !done)
    else $error("non-read transaction produced a result");

  a_frame_port_single: assert property (@(posedge clk) disable iff (rst)
    !(f_we && f_re) && !(pal_req.we && pal_req.re))
    else $error("store port used for read and write in one cycle");

endmodule
